### hw/rtl/assert_macros.svh
// Assertion macros used by the parser core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/cspf_pkg.sv
// Types and constants for the CO2 sensor frame parser.
`timescale 1ns / 1ps
package cspf_pkg;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_HEADER = 3'd1,
    ST_DATA   = 3'd2,
    ST_CHECK  = 3'd3
  } state_t;

  localparam logic [7:0]  START_BYTE     = 8'hFF;
  localparam logic [7:0]  CMD_BYTE       = 8'h86;
  localparam logic [3:0]  FIRST_DATA_POS = 4'd2;
  localparam logic [3:0]  LOW_DATA_POS   = 4'd3;
  localparam logic [3:0]  LAST_DATA_POS  = 4'd7;
  localparam logic [8:0]  WEIGHT_RESET   = 9'd256;
  localparam logic [15:0] PPM_MAX        = 16'hFFFF;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [15:0] ppm;
    logic        sum_match;
    logic [7:0]  computed_checksum;
    logic [7:0]  received_checksum;
  } result_t;

endpackage

### hw/rtl/cspf_in_reg.sv
// Input register stage: captures one beat and holds it until the parser takes it.
`timescale 1ns / 1ps
module cspf_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  cspf_pkg::item_t in_item,
  input  logic           take,
  output logic           s1_valid,
  output cspf_pkg::item_t s1_item
);
  import cspf_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  // Hold while a beat sits here and the parser cannot take it.
  assign in_stall = valid_r && !take;
  assign load     = !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

### hw/rtl/cspf_core.sv
// Frame parse state machine, checksum accumulation and concentration compute.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cspf_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  cspf_pkg::item_t  item,
  input  logic [8:0]       weight,
  output logic             res_valid,
  output cspf_pkg::result_t res
);
  import cspf_pkg::*;

  state_t     state_r, state_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] high_r, high_nxt;
  logic [7:0] low_r, low_nxt;

  logic [16:0] prod;
  logic [17:0] full;
  logic [7:0]  chk;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    if (step) begin
      if (item.command) begin
        state_nxt = ST_IDLE;
      end else begin
        case (state_r)
          ST_IDLE: begin
            if (item.rx_byte == START_BYTE) begin
              state_nxt = ST_HEADER;
            end
          end
          ST_HEADER: begin
            state_nxt = (item.rx_byte == CMD_BYTE) ? ST_DATA : ST_IDLE;
          end
          ST_DATA: begin
            if (pos_r >= LAST_DATA_POS) begin
              state_nxt = ST_CHECK;
            end
          end
          ST_CHECK: state_nxt = ST_IDLE;
          default:  state_nxt = ST_IDLE;
        endcase
      end
    end
  end

  assign prod = 17'(high_r) * 17'(weight);
  assign full = {1'b0, prod} + {10'd0, low_r};
  assign chk  = 8'h00 - sum_r;

  // Datapath updates and result.
  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    high_nxt  = high_r;
    low_nxt   = low_r;
    res_valid = 1'b0;
    res.ppm               = (full[17:16] != 2'd0) ? PPM_MAX : full[15:0];
    res.computed_checksum = chk;
    res.received_checksum = item.rx_byte;
    res.sum_match         = (chk == item.rx_byte);
    if (step) begin
      if (item.command) begin
        pos_nxt = 4'd0;
      end else begin
        case (state_r)
          ST_IDLE: begin
            pos_nxt = (item.rx_byte == START_BYTE) ? 4'd1 : 4'd0;
          end
          ST_HEADER: begin
            if (item.rx_byte == CMD_BYTE) begin
              sum_nxt = item.rx_byte;
              pos_nxt = FIRST_DATA_POS;
            end else begin
              pos_nxt = 4'd0;
            end
          end
          ST_DATA: begin
            sum_nxt = sum_r + item.rx_byte;
            if (pos_r == FIRST_DATA_POS) begin
              high_nxt = item.rx_byte;
            end else if (pos_r == LOW_DATA_POS) begin
              low_nxt = item.rx_byte;
            end
            pos_nxt = pos_r + 4'd1;
          end
          ST_CHECK: begin
            res_valid = 1'b1;
            pos_nxt   = 4'd0;
          end
          default: pos_nxt = 4'd0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= 4'd0;
      sum_r   <= 8'd0;
      high_r  <= 8'd0;
      low_r   <= 8'd0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      high_r  <= high_nxt;
      low_r   <= low_nxt;
    end
  end

  `ASSERT_IMPLIES(a_res_only_on_check, res_valid, step && !item.command && state_r == ST_CHECK, "result outside checksum byte")
  `ASSERT_NEXT(a_restart_idles, step && item.command, state_r == ST_IDLE && pos_r == 4'd0, "restart did not return to idle")
  `ASSERT_IMPLIES(a_data_pos_range, state_r == ST_DATA, pos_r >= FIRST_DATA_POS && pos_r <= LAST_DATA_POS, "data position out of range")

endmodule

### hw/rtl/cspf_out_reg.sv
// Result register: holds one result beat until the receiver takes it.
`timescale 1ns / 1ps
module cspf_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  output logic              can_load,
  input  logic              res_valid,
  input  cspf_pkg::result_t res,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_ppm,
  output logic              out_sum_match,
  output logic [7:0]        out_computed_checksum,
  output logic [7:0]        out_received_checksum
);
  import cspf_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign can_load = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (can_load) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid             = valid_r;
  assign out_ppm               = res_r.ppm;
  assign out_sum_match         = res_r.sum_match;
  assign out_computed_checksum = res_r.computed_checksum;
  assign out_received_checksum = res_r.received_checksum;

endmodule

### hw/rtl/co2_sensor_frame_parser_top.sv
// CO2 sensor reply frame parser: weight register, input stage, parser and result stage.
// Usage:
//   Input channel (in_valid / in_stall) carries one beat per received serial byte,
//   or a restart command (in_command = 1) that drops any partial frame.
//   A frame is 0xFF, 0x86, six data bytes, checksum. On the checksum beat one
//   result beat leaves on the output channel (out_valid / out_stall) with the
//   concentration high*weight+low (saturated at 65535) and the checksum check.
//   Every other beat produces no result.
//   cfg_wr_en / cfg_wr_data write the 9-bit high-byte weight; write it only
//   while no frame is in flight. It resets to 256.
// Timing:
//   One beat accepted per cycle unless out_stall holds a pending result.
//   out_valid rises once the checksum beat has passed the input register and its
//   result has been registered in the result register. The parser updates its
//   registered state on each beat it steps.
// Reset (synchronous, rst_n low): parser idle, both stages empty, weight 256.
// Stall: while out_stall holds a pending result, the parser holds the beat in its
//   input register and in_stall rises; a fresh beat is still taken while the
//   input register is empty.
`timescale 1ns / 1ps
module co2_sensor_frame_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_ppm,
  output logic        out_sum_match,
  output logic [7:0]  out_computed_checksum,
  output logic [7:0]  out_received_checksum
);
  import cspf_pkg::*;

  logic [8:0] weight_r, weight_nxt;
  item_t      in_item;
  item_t      s1_item;
  logic       s1_valid;
  logic       can_load;
  logic       step;
  logic       res_valid;
  result_t    res;

  always_comb begin
    weight_nxt = weight_r;
    if (cfg_wr_en) begin
      weight_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RESET;
    end else begin
      weight_r <= weight_nxt;
    end
  end

  assign in_item.command = in_command;
  assign in_item.rx_byte = in_rx_byte;

  // Advance the parser only when the result stage can take whatever it emits.
  assign step = s1_valid && can_load;

  cspf_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (can_load),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  cspf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (s1_item),
    .weight    (weight_r),
    .res_valid (res_valid),
    .res       (res)
  );

  cspf_out_reg u_out_reg (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .can_load              (can_load),
    .res_valid             (res_valid),
    .res                   (res),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_ppm               (out_ppm),
    .out_sum_match         (out_sum_match),
    .out_computed_checksum (out_computed_checksum),
    .out_received_checksum (out_received_checksum)
  );

endmodule

### tb/co2_sensor_frame_parser_top_test.sv
// Self-checking testbench for the CO2 sensor frame parser top level.
`timescale 1ns / 1ps
module co2_sensor_frame_parser_top_test;
  import cspf_pkg::*;

  localparam logic CMD_RX      = 1'b0;
  localparam logic CMD_RESTART = 1'b1;
  localparam int   LONG_HOLD_CYCLES = 300;
  localparam int   CYCLE_LIMIT      = 200000;

  typedef enum int {
    IDLE_NONE     = 0,
    IDLE_SENDER   = 1,
    IDLE_RECEIVER = 2,
    IDLE_BOTH     = 3
  } idle_mode_t;

  // Holds the expected parser state and the results still owed by the block.
  class ppm_scoreboard;
    logic [8:0] weight;
    state_t     state;
    logic [3:0] position;
    logic [7:0] running_sum;
    logic [7:0] high_byte;
    logic [7:0] low_byte;
    result_t    expected_results[$];
    int         failures;
    int         reported;

    function new();
      weight      = WEIGHT_RESET;
      state       = ST_IDLE;
      position    = '0;
      running_sum = '0;
      high_byte   = '0;
      low_byte    = '0;
      failures    = 0;
      reported    = 0;
    endfunction

    function void set_weight(logic [8:0] w);
      weight = w;
    endfunction

    function int pending_count();
      return expected_results.size();
    endfunction

    function void report_failure(string msg);
      failures++;
      if (reported < 10) begin
        $display("%s", msg);
        reported++;
      end
    endfunction

    function void note_beat(logic cmd, logic [7:0] b);
      int unsigned product;
      result_t     r;
      if (cmd == CMD_RESTART) begin
        state    = ST_IDLE;
        position = '0;
        return;
      end
      case (state)
        ST_IDLE: begin
          position = '0;
          if (b == START_BYTE) begin
            state    = ST_HEADER;
            position = 4'd1;
          end
        end
        ST_HEADER: begin
          if (b == CMD_BYTE) begin
            state       = ST_DATA;
            running_sum = b;
            position    = FIRST_DATA_POS;
          end else begin
            state    = ST_IDLE;
            position = '0;
          end
        end
        ST_DATA: begin
          running_sum = running_sum + b;
          if (position == FIRST_DATA_POS) high_byte = b;
          else if (position == LOW_DATA_POS) low_byte = b;
          if (position >= LAST_DATA_POS) state = ST_CHECK;
          position = position + 4'd1;
        end
        ST_CHECK: begin
          product = high_byte * weight + low_byte;
          r.ppm               = (product > PPM_MAX) ? PPM_MAX : product[15:0];
          r.computed_checksum = 8'd0 - running_sum;
          r.received_checksum = b;
          r.sum_match         = (r.computed_checksum == b);
          expected_results.push_back(r);
          state    = ST_IDLE;
          position = '0;
        end
        default: begin
          state    = ST_IDLE;
          position = '0;
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report_failure($sformatf("unexpected result: ppm %0d ok %0b chk %02h rcv %02h",
                                 got.ppm, got.sum_match, got.computed_checksum,
                                 got.received_checksum));
        return;
      end
      want = expected_results.pop_front();
      if (got.ppm !== want.ppm || got.sum_match !== want.sum_match ||
          got.computed_checksum !== want.computed_checksum ||
          got.received_checksum !== want.received_checksum) begin
        report_failure($sformatf({"result mismatch: ppm exp %0d got %0d, ok exp %0b got %0b,",
                                  " chk exp %02h got %02h, rcv exp %02h got %02h"},
                                 want.ppm, got.ppm, want.sum_match, got.sum_match,
                                 want.computed_checksum, got.computed_checksum,
                                 want.received_checksum, got.received_checksum));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [8:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = CMD_RX;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_ppm;
  logic        out_sum_match;
  logic [7:0]  out_computed_checksum;
  logic [7:0]  out_received_checksum;

  ppm_scoreboard sb = new();
  idle_mode_t    idle_mode = IDLE_NONE;
  int            sender_pct[4]   = '{0, 77, 0, 28};
  int            receiver_pct[4] = '{0, 0, 77, 28};
  int            hold_requests = 0;
  int            hold_served = 0;
  int            hold_left = 0;

  co2_sensor_frame_parser_top dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_command            (in_command),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_ppm               (out_ppm),
    .out_sum_match         (out_sum_match),
    .out_computed_checksum (out_computed_checksum),
    .out_received_checksum (out_received_checksum)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[co2_sensor_frame_parser_top] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_beat(in_command, in_rx_byte);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_ppm, out_sum_match, out_computed_checksum,
                       out_received_checksum});
  end

  // Receiver: long hold on request, otherwise random stalls per phase.
  always @(negedge clk) begin
    if (hold_left == 0 && hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_pct[idle_mode]);
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Enter and leave at a falling edge; hold the beat until it is taken.
  task automatic send_beat(input logic cmd, input logic [7:0] b);
    while ($urandom_range(99) < sender_pct[idle_mode]) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame(input bit corrupt_checksum);
    logic [7:0] data_byte;
    logic [7:0] sum;
    logic [7:0] chk;
    send_beat(CMD_RX, START_BYTE);
    send_beat(CMD_RX, CMD_BYTE);
    sum = CMD_BYTE;
    repeat (6) begin
      data_byte = pick_byte();
      sum = sum + data_byte;
      send_beat(CMD_RX, data_byte);
    end
    chk = 8'd0 - sum;
    if (corrupt_checksum) chk = chk ^ 8'($urandom_range(1, 255));
    send_beat(CMD_RX, chk);
  endtask

  task automatic send_stream(input int target, input bit with_hold);
    int         sent;
    int         kind;
    int         n;
    bit         hold_issued;
    logic [7:0] b;
    sent = 0;
    hold_issued = 1'b0;
    while (sent < target) begin
      if (with_hold && !hold_issued && sent >= 40) begin
        hold_requests++;
        hold_issued = 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 55) begin
        send_frame(1'b0);
        sent += 9;
      end else if (kind < 70) begin
        send_frame(1'b1);
        sent += 9;
      end else if (kind < 78) begin
        // broken header, sometimes a second start byte
        b = ($urandom_range(3) == 0) ? START_BYTE : pick_byte();
        if (b == CMD_BYTE) b = b ^ 8'h01;
        send_beat(CMD_RX, START_BYTE);
        send_beat(CMD_RX, b);
        sent += 2;
      end else if (kind < 86) begin
        // drop a partial frame, possibly right at the checksum beat
        n = $urandom_range(6);
        send_beat(CMD_RX, START_BYTE);
        send_beat(CMD_RX, CMD_BYTE);
        repeat (n) send_beat(CMD_RX, pick_byte());
        send_beat(CMD_RESTART, pick_byte());
        sent += 3 + n;
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) send_beat(1'($urandom_range(1)), pick_byte());
        sent += n;
      end
    end
  endtask

  // Park the parser in idle and wait for every owed result.
  task automatic finish_phase();
    send_beat(CMD_RESTART, pick_byte());
    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_weight(input logic [8:0] w);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_weight(w);
    @(negedge clk);
  endtask

  initial begin
    logic [8:0] phase_weight[5];
    idle_mode_t phase_mode[5];
    bit         phase_hold[5];
    phase_weight = '{9'd1, 9'd511, 9'd0, 9'($urandom_range(2, 255)), WEIGHT_RESET};
    phase_mode   = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE};
    phase_hold   = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // checksum failure on an all-zero frame
    send_beat(CMD_RX, START_BYTE);
    send_beat(CMD_RX, CMD_BYTE);
    repeat (6) send_beat(CMD_RX, 8'h00);
    send_beat(CMD_RX, 8'h00);
    // a start byte in the header slot is not a fresh start
    send_beat(CMD_RX, START_BYTE);
    send_beat(CMD_RX, START_BYTE);
    send_beat(CMD_RX, CMD_BYTE);
    // restart in the middle of a frame
    send_beat(CMD_RX, START_BYTE);
    send_beat(CMD_RX, CMD_BYTE);
    send_beat(CMD_RX, 8'h12);
    send_beat(CMD_RESTART, 8'hFF);
    // all data bytes at maximum, good checksum
    send_beat(CMD_RX, START_BYTE);
    send_beat(CMD_RX, CMD_BYTE);
    repeat (6) send_beat(CMD_RX, 8'hFF);
    send_beat(CMD_RX, 8'h80);
    finish_phase();

    for (int p = 0; p < 5; p++) begin
      write_weight(phase_weight[p]);
      idle_mode = phase_mode[p];
      send_stream(205, phase_hold[p]);
      finish_phase();
    end

    idle_mode = IDLE_NONE;
    repeat (10) @(negedge clk);
    if (sb.failures == 0 && sb.pending_count() == 0) begin
      $display("[co2_sensor_frame_parser_top] OK");
    end else begin
      $display("[co2_sensor_frame_parser_top] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/cspf_pkg.sv
hw/rtl/cspf_in_reg.sv
hw/rtl/cspf_core.sv
hw/rtl/cspf_out_reg.sv
hw/rtl/co2_sensor_frame_parser_top.sv
tb/co2_sensor_frame_parser_top_test.sv
